### hw/rtl/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;
    localparam int DATA_WORDS   = 128;
    localparam int STACK_WORDS  = 128;
    localparam int TILE_COLUMNS = 64;
    localparam int TILE_ROWS    = 32;
    localparam int DATA_AW  = $clog2(DATA_WORDS);
    localparam int STACK_AW = $clog2(STACK_WORDS);
    localparam int TILE_COUNT = TILE_COLUMNS * TILE_ROWS;

    localparam logic [31:0] RST_DATA_BASE = 32'd268500992;
    localparam logic [31:0] RST_KEY_PORT  = 32'hFFFF0000;
    localparam logic [31:0] RST_TEXT_BASE = 32'd4194304;
    localparam logic [31:0] RST_GP = 32'd268468224;
    localparam logic [31:0] RST_SP = 32'd2147479548;

    localparam logic [1:0] CFG_DATA_BASE = 2'd0;
    localparam logic [1:0] CFG_KEY_PORT  = 2'd1;
    localparam logic [1:0] CFG_TEXT_BASE = 2'd2;

    localparam logic [5:0] OP_RTYPE = 6'd0,  OP_J = 6'd2,    OP_JAL = 6'd3;
    localparam logic [5:0] OP_BEQ = 6'd4,    OP_BNE = 6'd5,  OP_BLEZ = 6'd6;
    localparam logic [5:0] OP_ADDI = 6'd8,   OP_ADDIU = 6'd9, OP_SLTI = 6'd10;
    localparam logic [5:0] OP_ORI = 6'd13,   OP_LUI = 6'd15;
    localparam logic [5:0] OP_LW = 6'd35,    OP_SW = 6'd43;
    localparam logic [5:0] FN_SLL = 6'd0,    FN_JR = 6'd8,   FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_ADD = 6'd32,   FN_ADDU = 6'd33, FN_SUB = 6'd34;
    localparam logic [5:0] FN_XOR = 6'd38,   FN_SLT = 6'd42;

    typedef struct packed {
        logic [31:0] pc_next;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        tile_paint;
        logic [10:0] tile_index;
        logic [31:0] tile_rgba;
        logic        delay_request;
        logic [30:0] delay_ms;
        logic        halt;
    } t_result;

    // palette lookup: returns {hit, rgba}
    function automatic logic [32:0] pal_lookup(input logic [31:0] key);
        logic [32:0] res;
        case (key)
            32'd0:        res = {1'b1, 32'hff222222};
            32'd16744448: res = {1'b1, 32'hff22ff11};
            32'd12583040: res = {1'b1, 32'hff2222ff};
            32'd16777215: res = {1'b1, 32'hffffffff};
            32'd1245175:  res = {1'b1, 32'hffe28743};
            32'd16776960: res = {1'b1, 32'hff22ffff};
            32'd65280:    res = {1'b1, 32'hff22ff11};
            32'd16711680: res = {1'b1, 32'hff2222ff};
            32'd65471:    res = {1'b1, 32'hff22aa00};
            32'd16753152: res = {1'b1, 32'hff2222aa};
            32'd9700348:  res = {1'b1, 32'h55aaaa00};
            default:      res = 33'd0;
        endcase
        return res;
    endfunction
endpackage

### hw/rtl/mse_ram.sv
`timescale 1ns / 1ps
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### hw/rtl/mse_mem_bank.sv
`timescale 1ns / 1ps
module mse_mem_bank (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_st_we,
    input  logic [mse_pkg::STACK_AW-1:0] i_st_waddr,
    input  logic [mse_pkg::STACK_AW-1:0] i_st_raddr,
    input  logic                         i_dt_we,
    input  logic [mse_pkg::DATA_AW-1:0]  i_dt_waddr,
    input  logic [mse_pkg::DATA_AW-1:0]  i_dt_raddr,
    input  logic [31:0]                  i_wdata,
    output logic [31:0]                  o_st_rdata,
    output logic [31:0]                  o_dt_rdata
);
    import mse_pkg::*;

    // stack and data words, with valid bits so unwritten words read zero
    logic [STACK_WORDS-1:0] r_st_valid;
    logic [DATA_WORDS-1:0]  r_dt_valid;
    logic                   r_st_rvalid, r_dt_rvalid;
    logic [31:0]            w_st_ram, w_dt_ram;

    mse_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack_ram (
        .i_clk(i_clk), .i_we(i_st_we), .i_waddr(i_st_waddr), .i_wdata(i_wdata),
        .i_raddr(i_st_raddr), .o_rdata(w_st_ram)
    );
    mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
        .i_clk(i_clk), .i_we(i_dt_we), .i_waddr(i_dt_waddr), .i_wdata(i_wdata),
        .i_raddr(i_dt_raddr), .o_rdata(w_dt_ram)
    );

    // valid bits follow the writes, read alongside the ram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid  <= '0;
            r_dt_valid  <= '0;
            r_st_rvalid <= 1'b0;
            r_dt_rvalid <= 1'b0;
        end else begin
            r_st_rvalid <= r_st_valid[i_st_raddr];
            r_dt_rvalid <= r_dt_valid[i_dt_raddr];
            if (i_st_we) begin
                r_st_valid[i_st_waddr] <= 1'b1;
            end
            if (i_dt_we) begin
                r_dt_valid[i_dt_waddr] <= 1'b1;
            end
        end
    end
    assign o_st_rdata = r_st_rvalid ? w_st_ram : 32'd0;
    assign o_dt_rdata = r_dt_rvalid ? w_dt_ram : 32'd0;
endmodule

### hw/rtl/mips_subset_execute_step.sv
`timescale 1ns / 1ps
// Executes one instruction word per cycle, back to back, unless the output
// stalls. A word is taken whenever the output register is empty or being
// drained; it passes stage one, then the output register. The register file
// is held in flip-flops; data and stack words sit in RAMs whose registered
// read is issued when the word is accepted and finished in the next cycle,
// with forwarding from the previous store; while the word waits in stage one
// the read is repeated at its own address. Register writes land at the edge
// that frees stage one, so the next word reads them from the register file.
module mips_subset_execute_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // instr_word[31:0], key_code[39:32], key_escape[40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc_next, reg_write, reg_index, reg_value, tile_paint, tile_index,
    // tile_rgba, delay_request, delay_ms, halt
    output logic [151:0] m_axis_tdata
);
    import mse_pkg::*;

    logic [31:0] r_data_base, r_key_port, r_text_base;
    logic [31:0] r_rf [32];
    logic [31:0] r_pc;

    // stage 1: accepted word waiting for memory read data
    logic        r_v1;
    logic [47:0] r_in1;
    logic        r_ov;
    t_result     r_out;

    logic        w_adv;
    assign w_adv = r_v1 && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_v1 || w_adv;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= RST_DATA_BASE;
            r_key_port  <= RST_KEY_PORT;
            r_text_base <= RST_TEXT_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_BASE: r_data_base <= i_cfg_data;
                CFG_KEY_PORT:  r_key_port  <= i_cfg_data;
                CFG_TEXT_BASE: r_text_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // read addresses for an incoming word come straight from its immediate
    logic [15:0] w_imm_in;
    logic [31:0] w_immx_in, w_imm4_in, w_rd_imm4;
    assign w_imm_in  = s_axis_tdata[15:0];
    assign w_immx_in = {{16{w_imm_in[15]}}, w_imm_in};
    assign w_imm4_in = $signed(w_immx_in + (w_immx_in[31] ? 32'd3 : 32'd0)) >>> 2;

    logic               w_st_we, w_dt_we;
    logic [STACK_AW-1:0] w_st_wa;
    logic [DATA_AW-1:0]  w_dt_wa;
    logic [31:0]         w_st_rd, w_dt_rd, w_st_wd;

    mse_mem_bank u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_st_we(w_st_we), .i_st_waddr(w_st_wa), .i_st_raddr(w_rd_imm4[STACK_AW-1:0]),
        .i_dt_we(w_dt_we), .i_dt_waddr(w_dt_wa), .i_dt_raddr(w_rd_imm4[DATA_AW-1:0]),
        .i_wdata(w_st_wd), .o_st_rdata(w_st_rd), .o_dt_rdata(w_dt_rd)
    );

    // store written at the same edge that the read was issued needs forwarding
    logic               r_fst, r_fdt;
    logic [31:0]        r_fwd;

    // execute
    logic [31:0] ins, a, b, immx, imm4, npc, wval, dms, rgba, gdiff, tn;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic        wr, paint, dly, hlt, st_ok, dt_ok;
    logic [32:0] pal;
    logic [31:0] sval, dval;
    logic [32:0] tgt, tq;
    t_result     w_res;

    always_comb begin
        ins  = r_in1[31:0];
        op   = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
        rd   = ins[15:11]; sh = ins[10:6];  fn = ins[5:0];
        immx = {{16{ins[15]}}, ins[15:0]};
        imm4 = $signed(immx + (immx[31] ? 32'd3 : 32'd0)) >>> 2;
        a    = r_rf[rs];
        b    = r_rf[rt];
        st_ok = !imm4[31] && (imm4 < STACK_WORDS);
        dt_ok = !imm4[31] && (imm4 < DATA_WORDS);
        sval = !st_ok ? 32'd0 : (r_fst ? r_fwd : w_st_rd);
        dval = !dt_ok ? 32'd0 : (r_fdt ? r_fwd : w_dt_rd);
        gdiff = a - r_rf[28];
        tn   = $signed(gdiff + (gdiff[31] ? 32'd3 : 32'd0)) >>> 2;
        pal  = pal_lookup(b);
        // signed 33-bit difference, divided by four truncating toward zero
        tgt  = {5'd0, ins[25:0], 2'b00} - {1'b0, r_text_base};
        tq   = $signed(tgt + (tgt[32] ? 33'd3 : 33'd0)) >>> 2;
        npc  = r_pc + 32'd1;
        wr = 1'b0; paint = 1'b0; dly = 1'b0; hlt = 1'b0;
        widx = rt; wval = '0; dms = '0; rgba = '0;
        w_st_we = 1'b0; w_dt_we = 1'b0;
        case (op)
            OP_RTYPE: begin
                widx = rd;
                case (fn)
                    FN_SYSCALL: begin
                        if (r_rf[2] == 32'd32) begin
                            dly = 1'b1;
                            dms = r_rf[4][31] ? 32'd0 : r_rf[4];
                        end
                    end
                    FN_ADD, FN_ADDU: begin wr = 1'b1; wval = a + b; end
                    FN_SUB: begin wr = 1'b1; wval = a - b; end
                    FN_SLT: begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
                    FN_SLL: begin wr = 1'b1; wval = b << sh; end
                    FN_JR:  npc = a;
                    FN_XOR: begin wr = 1'b1; wval = a ^ b; end
                    default: begin hlt = 1'b1; npc = r_pc; end
                endcase
            end
            OP_J, OP_JAL: begin
                npc = tq[31:0];
                if (op == OP_JAL) begin
                    wr = 1'b1; widx = 5'd31; wval = r_pc + 32'd1;
                end
            end
            OP_ADDIU: begin wr = 1'b1; wval = a + immx; end
            OP_ADDI:  begin wr = 1'b1; wval = (rt == 5'd29) ? a + imm4 : a + immx; end
            OP_LUI:   begin wr = 1'b1; wval = {ins[15:0], 16'd0}; end
            OP_ORI:   begin wr = 1'b1; wval = a | {16'd0, ins[15:0]}; end
            OP_SLTI:  begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(immx)}; end
            OP_BEQ:   if (a == b) npc = r_pc + 32'd1 + immx;
            OP_BNE:   if (a != b) npc = r_pc + 32'd1 + immx;
            OP_BLEZ:  if ($signed(a) <= 0) npc = r_pc + 32'd1 + immx;
            OP_LW: begin
                if (rs == 5'd29) begin wr = 1'b1; wval = sval; end
                if (a == r_data_base) begin wr = 1'b1; wval = dval; end
                if (a == r_key_port) begin
                    if (r_in1[39:32] != 8'd0) begin
                        wr = 1'b1; wval = {24'd0, r_in1[39:32]};
                    end
                    if (r_in1[40]) hlt = 1'b1;
                end
            end
            OP_SW: begin
                w_st_we = w_adv && (rs == 5'd29) && st_ok;
                w_dt_we = w_adv && (a == r_data_base) && dt_ok;
                if ((rs == 5'd2 || rs == 5'd10) && !tn[31] && (tn < TILE_COUNT) && pal[32]) begin
                    paint = 1'b1; rgba = pal[31:0];
                end
            end
            default: begin hlt = 1'b1; npc = r_pc; end
        endcase
        if (widx == 5'd0) wr = 1'b0;
        if (!wr) begin widx = '0; wval = '0; end
        w_st_wa = imm4[STACK_AW-1:0];
        w_dt_wa = imm4[DATA_AW-1:0];
        w_st_wd = b;
        w_res.pc_next = npc;
        w_res.reg_write = wr;
        w_res.reg_index = widx;
        w_res.reg_value = wval;
        w_res.tile_paint = paint;
        w_res.tile_index = paint ? tn[10:0] : 11'd0;
        w_res.tile_rgba = rgba;
        w_res.delay_request = dly;
        w_res.delay_ms = dms[30:0];
        w_res.halt = hlt;
    end

    // read address: incoming word when one is taken, else the held word
    assign w_rd_imm4 = s_axis_tready ? w_imm4_in : imm4;

    // pipeline, register file and pc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_ov <= 1'b0; r_pc <= '0;
            r_fst <= 1'b0; r_fdt <= 1'b0;
            for (int i = 0; i < 32; i++) begin
                r_rf[i] <= (i == 28) ? RST_GP : ((i == 29) ? RST_SP : 32'd0);
            end
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
                r_in1 <= s_axis_tdata;
                r_fst <= w_st_we && (w_st_wa == w_imm4_in[STACK_AW-1:0]);
                r_fdt <= w_dt_we && (w_dt_wa == w_imm4_in[DATA_AW-1:0]);
                r_fwd <= w_st_wd;
            end
            if (w_adv) begin
                r_ov <= 1'b1;
                r_out <= w_res;
                r_pc <= w_res.pc_next;
                if (w_res.reg_write) r_rf[w_res.reg_index] <= w_res.reg_value;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {5'd0, r_out.halt, r_out.delay_ms, r_out.delay_request,
        r_out.tile_rgba, r_out.tile_index, r_out.tile_paint, r_out.reg_value,
        r_out.reg_index, r_out.reg_write, r_out.pc_next};

    // stage one stalls only while a result waits unclaimed at the output
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_adv) |-> (r_ov && !m_axis_tready))
        else $error("stage one stalled without back pressure");
    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    // r0 is never written
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rf[0] == 32'd0) else $error("r0 nonzero");
endmodule
